@@ rtl/core/las_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// las_pkg
// Shared types and constants for the life automaton stepper.
// ----------------------------------------------------------------------------
package las_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [6:0] DIM_RESET = 7'd64;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_WR,
        ST_READ,
        ST_STEP_R0,
        ST_STEP_R1,
        ST_STEP_COL,
        ST_STEP_WR,
        ST_DONE
    } las_state_t;

    // three horizontally adjacent cells of one row
    typedef struct packed {
        logic left;
        logic mid;
        logic right;
    } las_row3_t;

    // 3x3 neighborhood around the cell under evaluation
    typedef struct packed {
        las_row3_t above;
        las_row3_t here;
        las_row3_t below;
        logic      active;
    } las_window_t;

    typedef struct packed {
        logic next_alive;
        logic died;
        logic born;
    } las_verdict_t;

endpackage : las_pkg
`default_nettype wire

@@ rtl/core/las_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// las_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module las_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : las_ram
`default_nettype wire

@@ rtl/core/las_rule.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// las_rule
// Shared B3/S23 evaluator: neighbor count and next state of one cell.
// ----------------------------------------------------------------------------
module las_rule
    import las_pkg::*;
(
    input  wire las_window_t win,
    output las_verdict_t     verdict
);

    logic [3:0] n_live;
    logic       alive;

    assign alive = win.here.mid;

    always_comb
    begin
        n_live = 4'(win.above.left) + 4'(win.above.mid) + 4'(win.above.right)
               + 4'(win.here.left)  + 4'(win.here.right)
               + 4'(win.below.left) + 4'(win.below.mid) + 4'(win.below.right);

        verdict.next_alive = alive;
        verdict.died       = 1'b0;
        verdict.born       = 1'b0;
        if (win.active)
        begin
            if (alive && (n_live < 4'd2 || n_live > 4'd3))
            begin
                verdict.next_alive = 1'b0;
                verdict.died       = 1'b1;
            end
            else if (!alive && n_live == 4'd3)
            begin
                verdict.next_alive = 1'b1;
                verdict.born       = 1'b1;
            end
        end
    end

endmodule : las_rule
`default_nettype wire

@@ rtl/core/life_automaton_stepper.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_automaton_stepper
// Bounded B3/S23 grid, one row per RAM word; a step walks it one cell per cycle
// within a row (pausing between rows) through a single shared rule unit.
// ----------------------------------------------------------------------------
// Load and read: ST_LOAD_WR or ST_READ, then ST_DONE; bad coordinate or unused
// command: straight to ST_DONE. One command in flight at a time; input is ready
// again from the cycle the result is presented.
// Step: for each row in use (capped at MAX_ROWS) the rule unit sweeps every
// column (MAX_COLS) of the row, then the row is written back; straight to
// ST_DONE with no rows in use.
// Reset: counters zero, dimensions 64; then a clearing pass writes all MAX_ROWS
// rows dead, with the input not ready until it finishes.
// ----------------------------------------------------------------------------
module life_automaton_stepper
    import las_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [5:0]  row_index,
    input  wire logic [5:0]  col_index,
    input  wire logic        cell_alive,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic             read_alive,
    output logic [31:0]      died_count,
    output logic [31:0]      born_count
);

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    las_state_t state_reg, state_next;

    logic [6:0]          rows_cfg_reg, cols_cfg_reg;
    logic [RCW-1:0]      rows_act;
    logic [CCW-1:0]      cols_act;

    logic [RAW-1:0]      r_reg;
    logic [CAW-1:0]      c_reg;
    logic [RAW-1:0]      clr_reg;
    logic [31:0]         died_reg, born_reg;
    logic                out_valid_reg;

    logic [CAW-1:0]      col_reg;
    logic                alive_reg;
    logic                res_status_reg, res_read_reg;
    logic [MAX_COLS-1:0] prv_reg, cur_reg, nxt_reg, new_reg;
    logic                lp_reg, lc_reg, ln_reg;
    logic                status_reg, read_alive_reg;
    logic [31:0]         died_out_reg, born_out_reg;

    logic                ram_we, ram_re;
    logic [RAW-1:0]      ram_waddr, ram_raddr;
    logic [MAX_COLS-1:0] ram_wdata, rd_data, load_row;

    logic                in_inside, in_fire, out_free;
    logic                has_row1, has_row2, col_on, right_on, last_col;
    las_window_t         win;
    las_verdict_t        verdict;

    assign rows_act = (32'(rows_cfg_reg) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_cfg_reg);
    assign cols_act = (32'(cols_cfg_reg) > 32'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cols_cfg_reg);

    assign in_inside = (32'(row_index) < 32'(rows_act)) && (32'(col_index) < 32'(cols_act));
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign has_row1 = (32'(r_reg) + 32'd1) < 32'(rows_act);
    assign has_row2 = (32'(r_reg) + 32'd2) < 32'(rows_act);
    assign col_on   = 32'(c_reg) < 32'(cols_act);
    assign right_on = (32'(c_reg) + 32'd1) < 32'(cols_act);
    assign last_col = (c_reg == CAW'(MAX_COLS - 1));

    always_comb
    begin
        load_row          = rd_data;
        load_row[col_reg] = alive_reg;
    end

    always_comb
    begin
        win.above.left  = lp_reg;
        win.above.mid   = prv_reg[0];
        win.above.right = prv_reg[1] & right_on;
        win.here.left   = lc_reg;
        win.here.mid    = cur_reg[0];
        win.here.right  = cur_reg[1] & right_on;
        win.below.left  = ln_reg;
        win.below.mid   = nxt_reg[0];
        win.below.right = nxt_reg[1] & right_on;
        win.active      = col_on;
    end

    las_rule u_rule (
        .win     (win),
        .verdict (verdict)
    );

    las_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // next state and RAM control
    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = r_reg;
        ram_wdata  = new_reg;
        ram_re     = 1'b0;
        ram_raddr  = RAW'(row_index);
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == RAW'(MAX_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_LOAD:
                        begin
                            ram_re     = in_inside;
                            state_next = in_inside ? ST_LOAD_WR : ST_DONE;
                        end
                        CMD_STEP:
                        begin
                            if (rows_act == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = ST_STEP_R0;
                            end
                        end
                        CMD_READ:
                        begin
                            ram_re     = in_inside;
                            state_next = in_inside ? ST_READ : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_LOAD_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = load_row;
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_STEP_R0:
            begin
                if (has_row1)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_reg + RAW'(1);
                    state_next = ST_STEP_R1;
                end
                else
                begin
                    state_next = ST_STEP_COL;
                end
            end
            ST_STEP_R1:
            begin
                state_next = ST_STEP_COL;
            end
            ST_STEP_COL:
            begin
                if (last_col)
                begin
                    state_next = ST_STEP_WR;
                end
            end
            ST_STEP_WR:
            begin
                ram_we = 1'b1;
                if (has_row1)
                begin
                    if (has_row2)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = r_reg + RAW'(2);
                        state_next = ST_STEP_R1;
                    end
                    else
                    begin
                        state_next = ST_STEP_COL;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control counters, totals, configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= DIM_RESET;
            cols_cfg_reg  <= DIM_RESET;
            clr_reg       <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            died_reg      <= '0;
            born_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROWS)
                begin
                    rows_cfg_reg <= cfg_data;
                end
                else if (cfg_index == REG_COLS)
                begin
                    cols_cfg_reg <= cfg_data;
                end
            end

            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + RAW'(1);
            end

            if (in_fire)
            begin
                r_reg <= (command == CMD_STEP) ? '0 : RAW'(row_index);
            end

            case (state_reg)
                ST_STEP_R0, ST_STEP_R1:
                begin
                    c_reg <= '0;
                end
                ST_STEP_COL:
                begin
                    c_reg <= c_reg + CAW'(1);
                    if (verdict.died && died_reg != COUNT_MAX)
                    begin
                        died_reg <= died_reg + 32'd1;
                    end
                    if (verdict.born && born_reg != COUNT_MAX)
                    begin
                        born_reg <= born_reg + 32'd1;
                    end
                end
                ST_STEP_WR:
                begin
                    c_reg <= '0;
                    if (has_row1)
                    begin
                        r_reg <= r_reg + RAW'(1);
                    end
                end
                default:
                begin
                end
            endcase

            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // row buffers and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            col_reg      <= CAW'(col_index);
            alive_reg    <= cell_alive;
            res_read_reg <= 1'b0;
            if (command == CMD_STEP)
            begin
                res_status_reg <= STATUS_OK;
            end
            else if ((command == CMD_LOAD || command == CMD_READ) && in_inside)
            begin
                res_status_reg <= STATUS_OK;
            end
            else
            begin
                res_status_reg <= STATUS_ERR;
            end
        end

        case (state_reg)
            ST_READ:
            begin
                res_read_reg <= rd_data[col_reg];
            end
            ST_STEP_R0:
            begin
                cur_reg <= rd_data;
                new_reg <= rd_data;
                prv_reg <= '0;
                lp_reg  <= 1'b0;
                lc_reg  <= 1'b0;
                ln_reg  <= 1'b0;
                if (!has_row1)
                begin
                    nxt_reg <= '0;
                end
            end
            ST_STEP_R1:
            begin
                nxt_reg <= rd_data;
                lp_reg  <= 1'b0;
                lc_reg  <= 1'b0;
                ln_reg  <= 1'b0;
            end
            ST_STEP_COL:
            begin
                lp_reg  <= prv_reg[0];
                lc_reg  <= cur_reg[0];
                ln_reg  <= nxt_reg[0];
                prv_reg <= {prv_reg[0], prv_reg[MAX_COLS-1:1]};
                cur_reg <= {cur_reg[0], cur_reg[MAX_COLS-1:1]};
                nxt_reg <= {nxt_reg[0], nxt_reg[MAX_COLS-1:1]};
                new_reg <= {verdict.next_alive, new_reg[MAX_COLS-1:1]};
            end
            ST_STEP_WR:
            begin
                prv_reg <= cur_reg;
                cur_reg <= nxt_reg;
                new_reg <= nxt_reg;
                lp_reg  <= 1'b0;
                lc_reg  <= 1'b0;
                ln_reg  <= 1'b0;
                if (!has_row2)
                begin
                    nxt_reg <= '0;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    status_reg     <= res_status_reg;
                    read_alive_reg <= res_read_reg;
                    died_out_reg   <= died_reg;
                    born_out_reg   <= born_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_alive = read_alive_reg;
    assign died_count = died_out_reg;
    assign born_count = born_out_reg;

endmodule : life_automaton_stepper
`default_nettype wire
